// ===== src/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cram_pkg
// Types, codes and reset values shared by the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

	// request function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
	localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

	localparam logic [6:0] DEV_ADDR_RST    = 7'h68;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	// byte slot within a transaction
	localparam logic [1:0] SLOT_ADDR = 2'd0;
	localparam logic [1:0] SLOT_REG  = 2'd1;
	localparam logic [1:0] SLOT_DATA = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE       = 4'd0,
		ST_START_FALL = 4'd1,
		ST_START_LOW  = 4'd2,
		ST_TX_LOW     = 4'd3,
		ST_TX_HIGH    = 4'd4,
		ST_ACK_LOW    = 4'd5,
		ST_ACK_HIGH   = 4'd6,
		ST_RS_LOW     = 4'd7,
		ST_RS_HIGH    = 4'd8,
		ST_RX_LOW     = 4'd9,
		ST_RX_HIGH    = 4'd10,
		ST_NACK_LOW   = 4'd11,
		ST_NACK_HIGH  = 4'd12,
		ST_STOP_LOW   = 4'd13,
		ST_STOP_HIGH  = 4'd14,
		ST_STOP_REL   = 4'd15
	} step_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       status;
	} rsp_t;

	typedef struct packed {
		logic [6:0] dev_addr;
		logic [7:0] ack_timeout;
	} cfg_t;

endpackage

// ===== src/i2cram_engine.sv =====
// ----------------------------------------------------------------------------
// i2cram_engine
// Half-bit phase sequencer: one advance per request beat, result is comb.
// ----------------------------------------------------------------------------
module i2cram_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  i2cram_pkg::req_t   req,
	input  i2cram_pkg::cfg_t   cfg,
	output i2cram_pkg::rsp_t   rsp
);

	i2cram_pkg::step_t step_q, step_d;
	logic [1:0] slot_q, slot_d;
	logic [3:0] bit_count_q, bit_count_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] poll_q, poll_d;
	logic       is_read_q, is_read_d;
	logic [7:0] sreg_q, sreg_d;
	logic [7:0] sdata_q, sdata_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic [7:0] last_read_q, last_read_d;
	logic       status_q, status_d;
	logic       done;
	logic [3:0] bit_inc;

	assign bit_inc = bit_count_q + 4'd1;

	always_comb begin
		step_d      = step_q;
		slot_d      = slot_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		poll_d      = poll_q;
		is_read_d   = is_read_q;
		sreg_d      = sreg_q;
		sdata_d     = sdata_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		last_read_d = last_read_q;
		status_d    = status_q;
		done        = 1'b0;
		case (step_q)
			i2cram_pkg::ST_IDLE: begin
				if (req.func == i2cram_pkg::FUNC_READ || req.func == i2cram_pkg::FUNC_WRITE) begin
					is_read_d   = (req.func == i2cram_pkg::FUNC_READ);
					sreg_d      = req.reg_addr;
					sdata_d     = req.write_data;
					status_d    = 1'b0;
					bit_count_d = 4'd0;
					poll_d      = 8'd0;
					step_d      = i2cram_pkg::ST_START_FALL;
					slot_d      = i2cram_pkg::SLOT_ADDR;
				end
			end
			i2cram_pkg::ST_START_FALL: begin
				scl_d  = 1'b1;
				sda_d  = 1'b0;
				step_d = i2cram_pkg::ST_START_LOW;
			end
			i2cram_pkg::ST_START_LOW: begin
				scl_d       = 1'b0;
				// repeated start happens only in the data slot of a read
				shift_d     = {cfg.dev_addr, slot_q == i2cram_pkg::SLOT_DATA};
				bit_count_d = 4'd0;
				step_d      = i2cram_pkg::ST_TX_LOW;
			end
			i2cram_pkg::ST_TX_LOW: begin
				scl_d  = 1'b0;
				sda_d  = shift_q[7];
				step_d = i2cram_pkg::ST_TX_HIGH;
			end
			i2cram_pkg::ST_TX_HIGH: begin
				scl_d       = 1'b1;
				shift_d     = {shift_q[6:0], 1'b0};
				bit_count_d = bit_inc;
				step_d      = (bit_inc >= 4'd8) ? i2cram_pkg::ST_ACK_LOW : i2cram_pkg::ST_TX_LOW;
			end
			i2cram_pkg::ST_ACK_LOW: begin
				scl_d  = 1'b0;
				sda_d  = 1'b1;
				poll_d = 8'd0;
				step_d = i2cram_pkg::ST_ACK_HIGH;
			end
			i2cram_pkg::ST_ACK_HIGH: begin
				scl_d = 1'b1;
				if (!req.sda_in) begin
					case (slot_q)
						i2cram_pkg::SLOT_ADDR: begin
							shift_d     = sreg_q;
							bit_count_d = 4'd0;
							slot_d      = i2cram_pkg::SLOT_REG;
							step_d      = i2cram_pkg::ST_TX_LOW;
						end
						i2cram_pkg::SLOT_REG: begin
							slot_d = i2cram_pkg::SLOT_DATA;
							if (is_read_q) begin
								step_d = i2cram_pkg::ST_RS_LOW;
							end else begin
								shift_d     = sdata_q;
								bit_count_d = 4'd0;
								step_d      = i2cram_pkg::ST_TX_LOW;
							end
						end
						default: begin
							slot_d = i2cram_pkg::SLOT_ADDR;
							if (is_read_q) begin
								shift_d     = 8'd0;
								bit_count_d = 4'd0;
								step_d      = i2cram_pkg::ST_RX_LOW;
							end else begin
								step_d = i2cram_pkg::ST_STOP_LOW;
							end
						end
					endcase
				end else if (poll_q >= cfg.ack_timeout) begin
					status_d = 1'b1;
					slot_d   = i2cram_pkg::SLOT_ADDR;
					step_d   = i2cram_pkg::ST_STOP_LOW;
				end else begin
					poll_d = poll_q + 8'd1;
				end
			end
			i2cram_pkg::ST_RS_LOW: begin
				scl_d  = 1'b0;
				sda_d  = 1'b1;
				step_d = i2cram_pkg::ST_RS_HIGH;
			end
			i2cram_pkg::ST_RS_HIGH: begin
				scl_d  = 1'b1;
				step_d = i2cram_pkg::ST_START_FALL;
			end
			i2cram_pkg::ST_RX_LOW: begin
				scl_d  = 1'b0;
				sda_d  = 1'b1;
				step_d = i2cram_pkg::ST_RX_HIGH;
			end
			i2cram_pkg::ST_RX_HIGH: begin
				scl_d       = 1'b1;
				shift_d     = {shift_q[6:0], req.sda_in};
				bit_count_d = bit_inc;
				step_d      = (bit_inc >= 4'd8) ? i2cram_pkg::ST_NACK_LOW : i2cram_pkg::ST_RX_LOW;
			end
			i2cram_pkg::ST_NACK_LOW: begin
				scl_d  = 1'b0;
				sda_d  = 1'b1;
				step_d = i2cram_pkg::ST_NACK_HIGH;
			end
			i2cram_pkg::ST_NACK_HIGH: begin
				scl_d  = 1'b1;
				step_d = i2cram_pkg::ST_STOP_LOW;
			end
			i2cram_pkg::ST_STOP_LOW: begin
				scl_d  = 1'b0;
				sda_d  = 1'b0;
				step_d = i2cram_pkg::ST_STOP_HIGH;
			end
			i2cram_pkg::ST_STOP_HIGH: begin
				scl_d  = 1'b1;
				step_d = i2cram_pkg::ST_STOP_REL;
			end
			i2cram_pkg::ST_STOP_REL: begin
				scl_d = 1'b1;
				sda_d = 1'b1;
				if (is_read_q && !status_q) begin
					last_read_d = shift_q;
				end
				step_d = i2cram_pkg::ST_IDLE;
				done   = 1'b1;
			end
			default: begin
				scl_d  = 1'b1;
				sda_d  = 1'b1;
				step_d = i2cram_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= i2cram_pkg::ST_IDLE;
			slot_q      <= i2cram_pkg::SLOT_ADDR;
			bit_count_q <= 4'd0;
			shift_q     <= 8'd0;
			poll_q      <= 8'd0;
			is_read_q   <= 1'b0;
			sreg_q      <= 8'd0;
			sdata_q     <= 8'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			last_read_q <= 8'd0;
			status_q    <= 1'b0;
		end else if (step_en) begin
			step_q      <= step_d;
			slot_q      <= slot_d;
			bit_count_q <= bit_count_d;
			shift_q     <= shift_d;
			poll_q      <= poll_d;
			is_read_q   <= is_read_d;
			sreg_q      <= sreg_d;
			sdata_q     <= sdata_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			last_read_q <= last_read_d;
			status_q    <= status_d;
		end
	end

	always_comb begin
		rsp.scl_level = scl_d;
		rsp.sda_level = sda_d;
		rsp.busy_res  = (step_d != i2cram_pkg::ST_IDLE);
		rsp.done_res  = done;
		rsp.read_data = last_read_d;
		rsp.status    = status_d;
	end

endmodule

// ===== src/i2c_register_access_master_top.sv =====
// ----------------------------------------------------------------------------
// i2c_register_access_master_top
// I2C master for single-register reads and writes, one half-bit per beat.
// ----------------------------------------------------------------------------
// Every request beat is one half-bit phase of the bus: a begin beat latches
// the operands and the following tick beats drive SCL/SDA and sample SDA.
// Each request gives exactly one response. The block takes one request per
// clock unless the response side stalls: a beat lands in the input register,
// and the phase sequencer advances on it as it moves into the response
// register.
// Configuration (device address, acknowledge timeout) is to be written while idle; the block does not enforce it.
module i2c_register_access_master_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  i2cram_pkg::req_t   req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output i2cram_pkg::rsp_t   rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	i2cram_pkg::cfg_t cfg_q;
	i2cram_pkg::req_t req_s1;
	i2cram_pkg::rsp_t rsp_next;
	logic             valid_s1;
	logic             adv_s1;
	logic             rsp_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr    <= i2cram_pkg::DEV_ADDR_RST;
			cfg_q.ack_timeout <= i2cram_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				i2cram_pkg::CFG_DEV_ADDR:    cfg_q.dev_addr    <= cfg_data[6:0];
				i2cram_pkg::CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rsp_free  = !rsp_valid || rsp_ready;
	assign adv_s1    = valid_s1 && rsp_free;
	assign req_ready = !valid_s1 || rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	i2cram_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv_s1),
		.req     (req_s1),
		.cfg     (cfg_q),
		.rsp     (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp <= rsp_next;
		end
	end

endmodule

// ===== bench/i2c_register_access_master_top_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_register_access_master_top_tb
// Self-checking bench for the I2C register access master.
// ----------------------------------------------------------------------------
// A short directed drill runs a read that loses its first acknowledge with a
// zero timeout, then random register reads and writes run under several
// address and timeout settings. Each request beat is predicted by a bus-phase
// model kept in this bench, and every response beat is compared field by
// field in order. Both handshakes stall at random.
module i2c_register_access_master_top_tb;

	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam i2cram_pkg::rsp_t RSP_IDLE = '{scl_level: 1'b1, sda_level: 1'b1,
		busy_res: 1'b0, done_res: 1'b0, read_data: 8'h00, status: 1'b0};
	localparam i2cram_pkg::rsp_t RSP_BEGIN = '{scl_level: 1'b1, sda_level: 1'b1,
		busy_res: 1'b1, done_res: 1'b0, read_data: 8'h00, status: 1'b0};
	localparam i2cram_pkg::rsp_t RSP_ABORT_DONE = '{scl_level: 1'b1, sda_level: 1'b1,
		busy_res: 1'b0, done_res: 1'b1, read_data: 8'h00, status: 1'b1};
	localparam i2cram_pkg::rsp_t RSP_ABORT_IDLE = '{scl_level: 1'b1, sda_level: 1'b1,
		busy_res: 1'b0, done_res: 1'b0, read_data: 8'h00, status: 1'b1};

	typedef struct packed {
		logic [1:0]       func;
		logic [7:0]       reg_addr;
		logic [7:0]       wdata;
		logic             sda;
		logic [4:0]       reps;
		logic             typed;
		i2cram_pkg::rsp_t want;
	} drill_row_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	i2cram_pkg::req_t req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	i2cram_pkg::rsp_t rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = '0;
	logic [7:0]       cfg_data = '0;

	// read with the address beat never acknowledged, timeout zero
	drill_row_t drill [12] = '{
		'{i2cram_pkg::FUNC_TICK,  8'h00, 8'h00, 1'b0, 5'd1, 1'b1, RSP_IDLE},
		'{FUNC_SPARE,             8'hFF, 8'hFF, 1'b1, 5'd1, 1'b1, RSP_IDLE},
		'{i2cram_pkg::FUNC_READ,  8'hFF, 8'h00, 1'b1, 5'd1, 1'b1, RSP_BEGIN},
		'{i2cram_pkg::FUNC_WRITE, 8'h00, 8'hFF, 1'b1, 5'd1, 1'b0, '0},
		'{FUNC_SPARE,             8'h55, 8'hAA, 1'b0, 5'd1, 1'b0, '0},
		'{i2cram_pkg::FUNC_TICK,  8'h00, 8'h00, 1'b1, 5'd8, 1'b0, '0},
		'{i2cram_pkg::FUNC_TICK,  8'hFF, 8'hFF, 1'b0, 5'd8, 1'b0, '0},
		'{i2cram_pkg::FUNC_TICK,  8'h00, 8'h00, 1'b0, 5'd1, 1'b0, '0},
		'{i2cram_pkg::FUNC_TICK,  8'h00, 8'h00, 1'b1, 5'd1, 1'b0, '0},
		'{i2cram_pkg::FUNC_TICK,  8'h00, 8'h00, 1'b0, 5'd2, 1'b0, '0},
		'{i2cram_pkg::FUNC_TICK,  8'h00, 8'h00, 1'b1, 5'd1, 1'b1, RSP_ABORT_DONE},
		'{i2cram_pkg::FUNC_TICK,  8'h00, 8'h00, 1'b0, 5'd1, 1'b1, RSP_ABORT_IDLE}
	};

	// bus-phase model state
	i2cram_pkg::step_t ph_step = i2cram_pkg::ST_IDLE;
	logic [1:0] ph_slot = i2cram_pkg::SLOT_ADDR;
	logic [3:0] bits = '0;
	logic [7:0] shreg = '0;
	logic [7:0] polls = '0;
	logic       rd_op = 1'b0;
	logic [7:0] reg_lat = '0;
	logic [7:0] data_lat = '0;
	logic       scl_q = 1'b1;
	logic       sda_q = 1'b1;
	logic [7:0] rd_byte = '0;
	logic       stat = 1'b0;
	logic [6:0] dev_addr = i2cram_pkg::DEV_ADDR_RST;
	logic [7:0] ack_tmo = i2cram_pkg::ACK_TIMEOUT_RST;

	i2cram_pkg::rsp_t pending_rsp [$];

	logic       steady = 1'b0;
	int         stuck_slot;
	logic [7:0] rx_byte;
	int n_err = 0;
	int n_rsp = 0;
	int n_live = 0;
	int n_reads = 0;
	int n_writes = 0;
	int n_done = 0;
	int n_abort = 0;
	int n_cfg = 0;

	i2c_register_access_master_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic void load_byte(input logic [7:0] value, input logic [1:0] slot);
		shreg = value;
		bits = '0;
		ph_step = i2cram_pkg::ST_TX_LOW;
		ph_slot = slot;
	endfunction

	function automatic i2cram_pkg::rsp_t predict_bus_beat(input i2cram_pkg::req_t b);
		i2cram_pkg::rsp_t r;
		logic done;
		done = 1'b0;
		if (ph_step == i2cram_pkg::ST_IDLE) begin
			if (b.func == i2cram_pkg::FUNC_READ || b.func == i2cram_pkg::FUNC_WRITE) begin
				rd_op = (b.func == i2cram_pkg::FUNC_READ);
				reg_lat = b.reg_addr;
				data_lat = b.write_data;
				stat = 1'b0;
				bits = '0;
				polls = '0;
				ph_step = i2cram_pkg::ST_START_FALL;
				ph_slot = i2cram_pkg::SLOT_ADDR;
				if (rd_op) n_reads++;
				else n_writes++;
			end
		end else begin
			case (ph_step)
				i2cram_pkg::ST_START_FALL: begin
					scl_q = 1'b1;
					sda_q = 1'b0;
					ph_step = i2cram_pkg::ST_START_LOW;
				end
				i2cram_pkg::ST_START_LOW: begin
					scl_q = 1'b0;
					// read address follows the repeated start
					load_byte({dev_addr, ph_slot == i2cram_pkg::SLOT_DATA}, ph_slot);
				end
				i2cram_pkg::ST_TX_LOW: begin
					scl_q = 1'b0;
					sda_q = shreg[7];
					ph_step = i2cram_pkg::ST_TX_HIGH;
				end
				i2cram_pkg::ST_TX_HIGH: begin
					scl_q = 1'b1;
					shreg = shreg << 1;
					bits = bits + 4'd1;
					if (bits >= 4'd8) ph_step = i2cram_pkg::ST_ACK_LOW;
					else ph_step = i2cram_pkg::ST_TX_LOW;
				end
				i2cram_pkg::ST_ACK_LOW: begin
					scl_q = 1'b0;
					sda_q = 1'b1;
					polls = '0;
					ph_step = i2cram_pkg::ST_ACK_HIGH;
				end
				i2cram_pkg::ST_ACK_HIGH: begin
					scl_q = 1'b1;
					if (!b.sda_in) begin
						if (ph_slot == i2cram_pkg::SLOT_ADDR) begin
							load_byte(reg_lat, i2cram_pkg::SLOT_REG);
						end else if (ph_slot == i2cram_pkg::SLOT_REG) begin
							if (rd_op) begin
								ph_step = i2cram_pkg::ST_RS_LOW;
								ph_slot = i2cram_pkg::SLOT_DATA;
							end else begin
								load_byte(data_lat, i2cram_pkg::SLOT_DATA);
							end
						end else if (rd_op) begin
							shreg = '0;
							bits = '0;
							ph_step = i2cram_pkg::ST_RX_LOW;
						end else begin
							ph_step = i2cram_pkg::ST_STOP_LOW;
						end
					end else if (polls >= ack_tmo) begin
						stat = 1'b1;
						ph_step = i2cram_pkg::ST_STOP_LOW;
					end else begin
						polls = polls + 8'd1;
					end
				end
				i2cram_pkg::ST_RS_LOW: begin
					scl_q = 1'b0;
					sda_q = 1'b1;
					ph_step = i2cram_pkg::ST_RS_HIGH;
				end
				i2cram_pkg::ST_RS_HIGH: begin
					scl_q = 1'b1;
					ph_step = i2cram_pkg::ST_START_FALL;
				end
				i2cram_pkg::ST_RX_LOW: begin
					scl_q = 1'b0;
					sda_q = 1'b1;
					ph_step = i2cram_pkg::ST_RX_HIGH;
				end
				i2cram_pkg::ST_RX_HIGH: begin
					scl_q = 1'b1;
					shreg = {shreg[6:0], b.sda_in};
					bits = bits + 4'd1;
					if (bits >= 4'd8) ph_step = i2cram_pkg::ST_NACK_LOW;
					else ph_step = i2cram_pkg::ST_RX_LOW;
				end
				i2cram_pkg::ST_NACK_LOW: begin
					scl_q = 1'b0;
					sda_q = 1'b1;
					ph_step = i2cram_pkg::ST_NACK_HIGH;
				end
				i2cram_pkg::ST_NACK_HIGH: begin
					scl_q = 1'b1;
					ph_step = i2cram_pkg::ST_STOP_LOW;
				end
				i2cram_pkg::ST_STOP_LOW: begin
					scl_q = 1'b0;
					sda_q = 1'b0;
					ph_step = i2cram_pkg::ST_STOP_HIGH;
				end
				i2cram_pkg::ST_STOP_HIGH: begin
					scl_q = 1'b1;
					ph_step = i2cram_pkg::ST_STOP_REL;
				end
				i2cram_pkg::ST_STOP_REL: begin
					scl_q = 1'b1;
					sda_q = 1'b1;
					if (rd_op && !stat) rd_byte = shreg;
					ph_step = i2cram_pkg::ST_IDLE;
					done = 1'b1;
					n_done++;
					if (stat) n_abort++;
				end
				default: begin
					scl_q = 1'b1;
					sda_q = 1'b1;
					ph_step = i2cram_pkg::ST_IDLE;
				end
			endcase
		end
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.busy_res = (ph_step != i2cram_pkg::ST_IDLE);
		r.done_res = done;
		r.read_data = rd_byte;
		r.status = stat;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (n_err < 100)
			$display("mismatch on response %0d: %s got %0h expected %0h", n_rsp, what, got, want);
		n_err++;
	endtask

	always @(negedge clk) begin
		rsp_ready <= steady || ($urandom_range(0, 99) >= 30);
	end

	always @(posedge clk) begin
		i2cram_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("response with none pending", int'(rsp), 0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.scl_level !== want.scl_level)
					report_mismatch("scl_level", rsp.scl_level, want.scl_level);
				if (rsp.sda_level !== want.sda_level)
					report_mismatch("sda_level", rsp.sda_level, want.sda_level);
				if (rsp.busy_res !== want.busy_res)
					report_mismatch("busy_res", rsp.busy_res, want.busy_res);
				if (rsp.done_res !== want.done_res)
					report_mismatch("done_res", rsp.done_res, want.done_res);
				if (rsp.read_data !== want.read_data)
					report_mismatch("read_data", rsp.read_data, want.read_data);
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
			end
			n_rsp++;
		end
	end

	// valid stays high from one beat to the next unless an idle cycle is rolled
	task automatic send_beat(input i2cram_pkg::req_t b, input logic typed,
		input i2cram_pkg::rsp_t typed_rsp);
		i2cram_pkg::rsp_t want;
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 30) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = b;
		req_valid = 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (ph_step != i2cram_pkg::ST_IDLE || b.func == i2cram_pkg::FUNC_READ
			|| b.func == i2cram_pkg::FUNC_WRITE) n_live++;
		want = predict_bus_beat(b);
		if (typed) want = typed_rsp;
		pending_rsp.push_back(want);
	endtask

	task automatic settle();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == i2cram_pkg::CFG_DEV_ADDR) dev_addr = val[6:0];
		else if (idx == i2cram_pkg::CFG_ACK_TIMEOUT) ack_tmo = val;
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic i2cram_pkg::req_t make_tick();
		i2cram_pkg::req_t b;
		b.func = i2cram_pkg::FUNC_TICK;
		b.reg_addr = 8'($urandom_range(0, 255));
		b.write_data = 8'($urandom_range(0, 255));
		b.sda_in = 1'($urandom_range(0, 1));
		// a begin or spare code mid-transfer is only a tick
		if ($urandom_range(0, 9) == 0) b.func = 2'($urandom_range(1, 3));
		if (ph_step == i2cram_pkg::ST_ACK_HIGH)
			b.sda_in = (int'(ph_slot) == stuck_slot) || ($urandom_range(0, 3) == 0);
		else if (ph_step == i2cram_pkg::ST_RX_HIGH)
			b.sda_in = rx_byte[3'd7 - bits[2:0]];
		return b;
	endfunction

	task automatic run_transfer();
		i2cram_pkg::req_t b;
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) begin
			b = make_tick();
			b.func = $urandom_range(0, 1) ? i2cram_pkg::FUNC_TICK : FUNC_SPARE;
			send_beat(b, 1'b0, '0);
		end
		// the slot equal to stuck_slot (0..2) never acknowledges; above 2, every slot acks normally
		stuck_slot = (stuck_slot == 99) ? 99 : $urandom_range(0, 14);
		rx_byte = pick_byte();
		b.func = $urandom_range(0, 1) ? i2cram_pkg::FUNC_READ : i2cram_pkg::FUNC_WRITE;
		b.reg_addr = pick_byte();
		b.write_data = pick_byte();
		b.sda_in = 1'($urandom_range(0, 1));
		send_beat(b, 1'b0, '0);
		while (ph_step != i2cram_pkg::ST_IDLE) begin
			if ($urandom_range(0, 199) == 0) settle();
			send_beat(make_tick(), 1'b0, '0);
		end
	endtask

	initial begin
		drill_row_t row;
		i2cram_pkg::req_t b;
		int i;
		int p;
		int target;
		int guard;
		logic [6:0] dev_set;
		logic [7:0] tmo_set;

		stuck_slot = 3;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		write_reg(i2cram_pkg::CFG_ACK_TIMEOUT, 8'd0);
		for (i = 0; i < 12; i++) begin
			row = drill[i];
			b.func = row.func;
			b.reg_addr = row.reg_addr;
			b.write_data = row.wdata;
			b.sda_in = row.sda;
			repeat (row.reps) send_beat(b, row.typed, row.want);
		end

		for (p = 0; p < 5; p++) begin
			settle();
			case (p)
				0: begin dev_set = 7'h00; tmo_set = 8'd1; end
				1: begin dev_set = 7'h7F; tmo_set = 8'd255; end
				2: begin
					dev_set = 7'($urandom_range(0, 127));
					tmo_set = 8'($urandom_range(1, 4));
				end
				3: begin dev_set = 7'h2A; tmo_set = 8'd0; end
				default: begin
					dev_set = 7'($urandom_range(0, 127));
					tmo_set = 8'($urandom_range(2, 8));
				end
			endcase
			write_reg(i2cram_pkg::CFG_DEV_ADDR, {1'b0, dev_set});
			write_reg(i2cram_pkg::CFG_ACK_TIMEOUT, tmo_set);
			// one phase with both sides streaming without gaps
			steady = (p == 1);
			target = n_live + 40;
			while (n_live < target) run_transfer();
			steady = 1'b0;
		end

		@(negedge clk);
		req_valid = 1'b0;
		guard = 0;
		while (pending_rsp.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending_rsp.size() != 0)
			report_mismatch("responses never returned", 0, pending_rsp.size());

		$display("ran %0d transfers (%0d reads, %0d writes), %0d aborted on a missing ack",
			n_done, n_reads, n_writes, n_abort);
		$display("%0d live request beats, %0d responses checked, %0d register writes",
			n_live, n_rsp, n_cfg);
		if (n_err == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/i2cram_pkg.sv
src/i2cram_engine.sv
src/i2c_register_access_master_top.sv
bench/i2c_register_access_master_top_tb.sv
